/* rtl/base91_encoder_top_assert.svh */
// assertion macros for the base91 encoder checker
// no dependencies; pulled in by the checker file
`ifndef BASE91_ENCODER_TOP_ASSERT_SVH
`define BASE91_ENCODER_TOP_ASSERT_SVH

// same-cycle implication
`define B91_ASSERT_NOW(lbl, clk, dis, a, b) \
  lbl: assert property (@(posedge clk) disable iff (dis) (a) |-> (b)) \
    else $error("b91 check failed");

// next-cycle implication
`define B91_ASSERT_NEXT(lbl, clk, dis, a, b) \
  lbl: assert property (@(posedge clk) disable iff (dis) (a) |=> (b)) \
    else $error("b91 check failed");

`endif

/* rtl/b91_pkg.sv */
// shared types, constants and the divide-by-91 helper
// no dependencies
package b91_pkg;

  localparam logic [3:0]  BYTE_BITS   = 4'd8;
  localparam logic [4:0]  SPLIT_SHORT = 5'd13;
  localparam logic [4:0]  SPLIT_LONG  = 5'd14;
  localparam logic [4:0]  FLUSH_ONE   = 5'd7;
  localparam logic [12:0] SMALL_LIMIT = 13'd88;
  localparam logic [12:0] DIGIT_MAX   = 13'd90;
  localparam logic [13:0] RADIX       = 14'd91;
  localparam logic [13:0] RECIP       = 14'd11523;
  localparam int          RECIP_SHIFT = 20;

  // slots of a job: ext mod, ext div, flush mod, flush div
  typedef struct packed {
    logic [13:0] v;
    logic [12:0] f;
    logic [3:0]  mask;
  } job_t;

  // floor(x / 91), exact for x below 11648
  function automatic logic [6:0] div91(input logic [13:0] x);
    logic [27:0] p;
    p = 28'(x) * 28'(RECIP);
    return p[RECIP_SHIFT+6:RECIP_SHIFT];
  endfunction

  // x - 91 * q, given q = floor(x / 91)
  function automatic logic [6:0] mod91(input logic [13:0] x, input logic [6:0] q);
    logic [13:0] prod;
    logic [13:0] diff;
    prod = {7'd0, q} * RADIX;
    diff = x - prod;
    return diff[6:0];
  endfunction

endpackage

/* rtl/b91_front.sv */
// front end: bit accumulator, extraction and flush decisions
// uses b91_pkg; feeds jobs into b91_jobq
module b91_front import b91_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  logic [7:0] in_data_byte,
  input  logic       in_end_of_message,
  input  logic       jq_full,
  output logic       jq_push,
  output job_t       jq_job
);

  logic [12:0] acc_r, acc_nxt;
  logic [3:0]  cnt_r, cnt_nxt;
  logic [20:0] merged;
  logic [20:0] rem;
  logic [4:0]  cnt_sum;
  logic [4:0]  rem_cnt;
  logic        accept;
  logic        ext;
  logic        take_long;
  logic        flush;
  logic        two;

  always_comb begin
    accept    = push && !jq_full;
    merged    = {8'd0, acc_r} | ({13'd0, in_data_byte} << cnt_r);
    cnt_sum   = {1'b0, cnt_r} + {1'b0, BYTE_BITS};
    ext       = cnt_sum > SPLIT_SHORT;
    take_long = merged[12:0] <= SMALL_LIMIT;
    if (!ext) begin
      rem     = merged;
      rem_cnt = cnt_sum;
    end else if (take_long) begin
      rem     = merged >> SPLIT_LONG;
      rem_cnt = cnt_sum - SPLIT_LONG;
    end else begin
      rem     = merged >> SPLIT_SHORT;
      rem_cnt = cnt_sum - SPLIT_SHORT;
    end
    flush = in_end_of_message && (rem_cnt != 5'd0);
    two   = (rem_cnt > FLUSH_ONE) || (rem[12:0] > DIGIT_MAX);

    jq_job.v    = take_long ? merged[13:0] : {1'b0, merged[12:0]};
    jq_job.f    = rem[12:0];
    jq_job.mask = {flush && two, flush, ext, ext};
    jq_push     = accept && (ext || flush);

    acc_nxt = acc_r;
    cnt_nxt = cnt_r;
    if (accept) begin
      if (in_end_of_message) begin
        acc_nxt = '0;
        cnt_nxt = '0;
      end else begin
        acc_nxt = rem[12:0];
        cnt_nxt = rem_cnt[3:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
      cnt_r <= '0;
    end else begin
      acc_r <= acc_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

/* rtl/b91_jobq.sv */
// two-entry job queue between front and back
// uses b91_pkg
module b91_jobq import b91_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic wr,
  input  job_t wr_job,
  output logic full,
  input  logic rd,
  output job_t rd_job,
  output logic empty
);

  job_t       ent_r [2];
  logic       wp_r, wp_nxt;
  logic       rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_wr, do_rd;

  always_comb begin
    full   = cnt_r == 2'd2;
    empty  = cnt_r == 2'd0;
    rd_job = ent_r[rp_r];
    do_wr  = wr && !full;
    do_rd  = rd && !empty;
    wp_nxt = do_wr ? !wp_r : wp_r;
    rp_nxt = do_rd ? !rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, do_wr} - {1'b0, do_rd};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      ent_r[wp_r] <= wr_job;
    end
  end

endmodule

/* rtl/b91_back.sv */
// back end: divide stage, digit sequencer and two-entry result queue
// uses b91_pkg; takes jobs from b91_jobq
module b91_back import b91_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  job_t       jq_job,
  input  logic       jq_empty,
  output logic       jq_pop,
  output logic       empty,
  input  logic       pop,
  output logic [6:0] out_digit,
  output logic       out_last_digit
);

  logic        dv_r, dv_nxt;
  logic [13:0] v_r;
  logic [12:0] f_r;
  logic [6:0]  qv_r;
  logic [6:0]  qf_r;
  logic [3:0]  mask_r, mask_nxt;
  logic [3:0]  lowest;
  logic [3:0]  mask_after;
  logic [6:0]  dig;
  logic        dig_last;
  logic        emit;
  logic        load;

  logic [6:0] od_r [2];
  logic       ol_r [2];
  logic       owp_r, orp_r;
  logic [1:0] ocnt_r, ocnt_nxt;
  logic       ofull;
  logic       do_pop;

  always_comb begin
    ofull      = ocnt_r == 2'd2;
    lowest     = mask_r & (~mask_r + 4'd1);
    mask_after = mask_r & ~lowest;
    dig_last   = mask_after == 4'd0;
    unique case (lowest)
      4'b0001: dig = mod91(v_r, qv_r);
      4'b0010: dig = qv_r;
      4'b0100: dig = mod91({1'b0, f_r}, qf_r);
      4'b1000: dig = qf_r;
      default: dig = '0;
    endcase
    emit   = dv_r && !ofull;
    load   = !dv_r || (emit && dig_last);
    jq_pop = load && !jq_empty;
    dv_nxt   = dv_r;
    mask_nxt = mask_r;
    if (load) begin
      dv_nxt   = !jq_empty;
      mask_nxt = jq_job.mask;
    end else if (emit) begin
      mask_nxt = mask_after;
    end
    do_pop   = pop && (ocnt_r != 2'd0);
    ocnt_nxt = ocnt_r + {1'b0, emit} - {1'b0, do_pop};
    empty          = ocnt_r == 2'd0;
    out_digit      = od_r[orp_r];
    out_last_digit = ol_r[orp_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_r   <= 1'b0;
      mask_r <= '0;
      owp_r  <= 1'b0;
      orp_r  <= 1'b0;
      ocnt_r <= '0;
    end else begin
      dv_r   <= dv_nxt;
      mask_r <= mask_nxt;
      ocnt_r <= ocnt_nxt;
      if (emit) begin
        owp_r <= !owp_r;
      end
      if (do_pop) begin
        orp_r <= !orp_r;
      end
    end
  end

  // quotient by reciprocal multiply, registered before the remainder
  always_ff @(posedge clk) begin
    if (jq_pop) begin
      v_r  <= jq_job.v;
      f_r  <= jq_job.f;
      qv_r <= div91(jq_job.v);
      qf_r <= div91({1'b0, jq_job.f});
    end
    if (emit) begin
      od_r[owp_r] <= dig;
      ol_r[owp_r] <= dig_last;
    end
  end

endmodule

/* rtl/base91_encoder_top.sv */
// base91 encoder top level: byte beats in, symbol values 0..90 out
// uses b91_pkg, b91_front, b91_jobq, b91_back
//
// input channel: a beat carries in_data_byte and in_end_of_message and is
//   taken at a clock edge with push high and full low
// result channel: while empty is low the oldest digit sits on out_digit and
//   out_last_digit; it is taken at an edge with pop high
// each byte gives zero to four digits; out_last_digit marks the final digit
//   caused by one byte
// path: job queue, then divide-stage registers, then result queue
// throughput: one digit per cycle on the result side while the result queue
//   has room, set by the digit sequencer in the back end;
//   the front takes a byte every cycle while the job queue has room
// the job queue holds at most two jobs; when the receiver stalls the result
//   queue and job queue fill and full goes high
// reset (rst_n low, synchronous) clears the bit accumulator, count and all
//   queues; digits not yet taken are dropped
module base91_encoder_top import b91_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_data_byte,
  input  logic       in_end_of_message,
  output logic       empty,
  input  logic       pop,
  output logic [6:0] out_digit,
  output logic       out_last_digit
);

  job_t fe_job;
  job_t jq_head;
  logic fe_push;
  logic jq_full;
  logic jq_empty;
  logic jq_pop;

  assign full = jq_full;

  b91_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .push              (push),
    .in_data_byte      (in_data_byte),
    .in_end_of_message (in_end_of_message),
    .jq_full           (jq_full),
    .jq_push           (fe_push),
    .jq_job            (fe_job)
  );

  b91_jobq u_jobq (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr     (fe_push),
    .wr_job (fe_job),
    .full   (jq_full),
    .rd     (jq_pop),
    .rd_job (jq_head),
    .empty  (jq_empty)
  );

  b91_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .jq_job         (jq_head),
    .jq_empty       (jq_empty),
    .jq_pop         (jq_pop),
    .empty          (empty),
    .pop            (pop),
    .out_digit      (out_digit),
    .out_last_digit (out_last_digit)
  );

endmodule

/* rtl/b91_checker.sv */
// port-level checks for the base91 encoder, bound to the top level
// uses base91_encoder_top_assert.svh
`include "base91_encoder_top_assert.svh"

module b91_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       push,
  input logic       full,
  input logic       empty,
  input logic       pop,
  input logic [6:0] out_digit,
  input logic       out_last_digit
);

  `B91_ASSERT_NOW(a_digit_range, clk, !rst_n, !empty, out_digit <= 7'd90)
  `B91_ASSERT_NEXT(a_reset_empty, clk, 1'b0, !rst_n, empty && !full)
  `B91_ASSERT_NEXT(a_hold_beat, clk, !rst_n, !empty && !pop, !empty && $stable(out_digit) && $stable(out_last_digit))
  `B91_ASSERT_NEXT(a_no_spurious, clk, !rst_n, empty && !push && rst_n, empty || !$stable(empty))

endmodule

bind base91_encoder_top b91_checker u_b91_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .push           (push),
  .full           (full),
  .empty          (empty),
  .pop            (pop),
  .out_digit      (out_digit),
  .out_last_digit (out_last_digit)
);
